@@ hw/rtl/cpm_pkg.sv @@
`timescale 1ns / 1ps

package cpm_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int COEF_BITS  = 16;
    localparam int FIELD_W    = 16;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 2 * COEF_BITS + 1;
    localparam int IDX_W      = $clog2(MAX_TERMS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TOT_W      = IDX_W + 1;
    localparam int RESULT_CAP = 31;
    localparam int IDX_OUT_W  = 5;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_PAD    = OUT_DATA_W - 2 * ACC_W - IDX_OUT_W;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] im;
        logic signed [COEF_BITS-1:0] re;
    } coef_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] im;
        logic signed [ACC_W-1:0] re;
    } acc_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic  clear;
        logic  adv;
        logic  shift;
        coef_t x;
    } cell_ctrl_t;

    // Take the low COEF_BITS bits of a field as a signed coefficient
    function automatic logic signed [COEF_BITS-1:0] to_coef(input logic [FIELD_W-1:0] f);
        return signed'(COEF_BITS'(f));
    endfunction

endpackage

@@ hw/rtl/cpm_cell.sv @@
`timescale 1ns / 1ps

module cpm_cell (
    input  logic               clk,
    input  cpm_pkg::cell_ctrl_t ctrl,
    input  logic               wr_en,
    input  logic               active,
    input  cpm_pkg::coef_t     a_in,
    input  cpm_pkg::coef_t     b_in,
    input  cpm_pkg::coef_t     b_next,
    input  cpm_pkg::acc_t      psum_in,
    output cpm_pkg::coef_t     b_out,
    output cpm_pkg::acc_t      psum_out
);
    import cpm_pkg::*;

    coef_t a_reg;
    coef_t b_reg;
    acc_t  prod_reg;
    acc_t  prod_next;
    acc_t  psum_reg;
    logic signed [PROD_W-1:0] mul_re;
    logic signed [PROD_W-1:0] mul_im;

    // One complex product per cycle against the broadcast operand
    always_comb
    begin
        mul_re = a_reg.re * ctrl.x.re - a_reg.im * ctrl.x.im;
        mul_im = a_reg.re * ctrl.x.im + a_reg.im * ctrl.x.re;
        if (active)
        begin
            prod_next.re = signed'(ACC_W'(mul_re));
            prod_next.im = signed'(ACC_W'(mul_im));
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        else if (ctrl.shift)
        begin
            b_reg <= b_next;
        end

        if (ctrl.clear)
        begin
            prod_reg <= '0;
            psum_reg <= '0;
        end
        else if (ctrl.adv)
        begin
            prod_reg    <= prod_next;
            psum_reg.re <= prod_reg.re + psum_in.re;
            psum_reg.im <= prod_reg.im + psum_in.im;
        end
    end

    assign b_out    = b_reg;
    assign psum_out = psum_reg;

endmodule

@@ hw/rtl/complex_poly_multiply_core.sv @@
// Loading: one coefficient pair per cycle, up to MAX_TERMS stored in the cell chain.
// Computing: after the word carrying tlast, each product word passes the product
// and partial-sum registers; words then follow one per cycle while m_axis_tready
// is high, topA+topB+1 words (one word if an operand is all zero), input not ready.
// Reset: rst_n asynchronous, active low; clears control state, ready to load.
`timescale 1ns / 1ps

module complex_poly_multiply_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_real [15:0], a_imag [31:16], b_real [47:32], b_imag [63:48]
    input  logic [cpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // prod_real [39:0], prod_imag [79:40], prod_index [84:80], zero pad [87:85]
    output logic [cpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import cpm_pkg::*;

    typedef enum logic {ST_LOAD, ST_RUN} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] load_cnt_reg;
    logic [IDX_W-1:0] top_a_reg;
    logic [IDX_W-1:0] top_b_reg;
    logic             nz_a_reg;
    logic             nz_b_reg;
    logic [IDX_W-1:0] top_a_next;
    logic [IDX_W-1:0] top_b_next;
    logic             nz_a_next;
    logic             nz_b_next;
    logic [TOT_W-1:0] sum_tops;
    logic [TOT_W-1:0] total_next;

    logic [IDX_W-1:0] top_a_run_reg;
    logic [IDX_W-1:0] top_b_run_reg;
    logic             nz_run_reg;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] step_reg;
    logic             feed_reg;
    logic             v1_reg;
    logic             last1_reg;
    logic [TOT_W-1:0] idx1_reg;
    logic             v2_reg;
    logic             last2_reg;
    logic [TOT_W-1:0] idx2_reg;

    logic             in_acc;
    logic             store_ok;
    logic             adv;
    coef_t            a_coef;
    coef_t            b_coef;
    logic             a_nz;
    logic             b_nz;
    cell_ctrl_t       ctrl;

    coef_t            b_w    [MAX_TERMS+1];
    acc_t             psum_w [MAX_TERMS+1];

    // Input word unpacking and handshake
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign store_ok  = load_cnt_reg < CNT_W'(MAX_TERMS);
    assign a_coef.re = to_coef(s_axis_tdata[FIELD_W-1:0]);
    assign a_coef.im = to_coef(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    assign b_coef.re = to_coef(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
    assign b_coef.im = to_coef(s_axis_tdata[4*FIELD_W-1:3*FIELD_W]);
    assign a_nz      = (a_coef.re != '0) || (a_coef.im != '0);
    assign b_nz      = (b_coef.re != '0) || (b_coef.im != '0);

    // Track the highest non-zero index of each operand, including this word
    always_comb
    begin
        top_a_next = top_a_reg;
        top_b_next = top_b_reg;
        nz_a_next  = nz_a_reg;
        nz_b_next  = nz_b_reg;
        if (in_acc && store_ok)
        begin
            if (a_nz)
            begin
                top_a_next = load_cnt_reg[IDX_W-1:0];
                nz_a_next  = 1'b1;
            end
            if (b_nz)
            begin
                top_b_next = load_cnt_reg[IDX_W-1:0];
                nz_b_next  = 1'b1;
            end
        end
        sum_tops = TOT_W'(top_a_next) + TOT_W'(top_b_next) + TOT_W'(1);
        if (!(nz_a_next && nz_b_next))
        begin
            total_next = TOT_W'(1);
        end
        else if (sum_tops > TOT_W'(RESULT_CAP))
        begin
            total_next = TOT_W'(RESULT_CAP);
        end
        else
        begin
            total_next = sum_tops;
        end
    end

    // Advance the chain whenever the output register is free or being drained
    assign adv           = !v2_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD);

    // Broadcast B[step] while it lies within B's non-zero span, else zero
    always_comb
    begin
        ctrl.clear = in_acc && s_axis_tlast;
        ctrl.adv   = (state_reg == ST_RUN) && adv;
        ctrl.shift = (state_reg == ST_RUN) && adv && feed_reg;
        if (feed_reg && nz_run_reg && (step_reg <= TOT_W'(top_b_run_reg)))
        begin
            ctrl.x = b_w[0];
        end
        else
        begin
            ctrl.x = '0;
        end
    end

    assign b_w[MAX_TERMS]    = '0;
    assign psum_w[MAX_TERMS] = '0;

    // Cell j holds A[j] and B[j]; B shifts towards cell 0, partial sums
    // ripple towards cell 0 one cell per advancing cycle (transposed convolution).
    for (genvar j = 0; j < MAX_TERMS; j++)
    begin : g_cell
        cpm_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .wr_en    (in_acc && (load_cnt_reg == CNT_W'(j))),
            .active   (IDX_W'(j) <= top_a_run_reg),
            .a_in     (a_coef),
            .b_in     (b_coef),
            .b_next   (b_w[j+1]),
            .psum_in  (psum_w[j+1]),
            .b_out    (b_w[j]),
            .psum_out (psum_w[j])
        );
    end

    // Sequencer: loading, then feeding and draining the product words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            top_a_reg     <= '0;
            top_b_reg     <= '0;
            nz_a_reg      <= 1'b0;
            nz_b_reg      <= 1'b0;
            top_a_run_reg <= '0;
            top_b_run_reg <= '0;
            nz_run_reg    <= 1'b0;
            total_reg     <= '0;
            step_reg      <= '0;
            feed_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            idx1_reg      <= '0;
            v2_reg        <= 1'b0;
            last2_reg     <= 1'b0;
            idx2_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tlast)
                        begin
                            // Hold the operand spans for the run, restart loading
                            load_cnt_reg  <= '0;
                            top_a_reg     <= '0;
                            top_b_reg     <= '0;
                            nz_a_reg      <= 1'b0;
                            nz_b_reg      <= 1'b0;
                            top_a_run_reg <= top_a_next;
                            top_b_run_reg <= top_b_next;
                            nz_run_reg    <= nz_a_next && nz_b_next;
                            total_reg     <= total_next;
                            step_reg      <= '0;
                            feed_reg      <= 1'b1;
                            state_reg     <= ST_RUN;
                        end
                        else
                        begin
                            if (store_ok)
                            begin
                                load_cnt_reg <= load_cnt_reg + CNT_W'(1);
                            end
                            top_a_reg <= top_a_next;
                            top_b_reg <= top_b_next;
                            nz_a_reg  <= nz_a_next;
                            nz_b_reg  <= nz_b_next;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        v1_reg    <= feed_reg;
                        idx1_reg  <= step_reg;
                        last1_reg <= (step_reg == total_reg - TOT_W'(1));
                        v2_reg    <= v1_reg;
                        idx2_reg  <= idx1_reg;
                        last2_reg <= last1_reg;
                        if (feed_reg)
                        begin
                            step_reg <= step_reg + TOT_W'(1);
                            if (step_reg == total_reg - TOT_W'(1))
                            begin
                                feed_reg <= 1'b0;
                            end
                        end
                        // Last word handed over: drop back to loading
                        if (!feed_reg && !v1_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Cell 0's partial sum register is the output register
    assign m_axis_tvalid = v2_reg;
    assign m_axis_tlast  = last2_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, IDX_OUT_W'(idx2_reg),
                            psum_w[0].im, psum_w[0].re};

`ifndef SYNTH
    // Loading and delivering never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a product word is pending");

    // The last mark sits exactly on the final coefficient of the run
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (idx2_reg == total_reg - TOT_W'(1))))
        else $error("last mark misplaced");

    // Words of one run follow each other without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a product run");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for complex_poly_multiply_core.
// Operand pairs go in as streams of coefficient words; product words come back
// and are compared field by field against a behavioural model held in this file.
module tb;
    import cpm_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 4;
    localparam int WORD_GOAL   = 410;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_TICKS = 60;
    localparam int HOLD_TICKS  = 400;
    localparam int REPORT_MAX  = 10;

    // One product word as the block should present it
    typedef struct packed {
        logic signed [ACC_W-1:0]  re;
        logic signed [ACC_W-1:0]  im;
        logic [IDX_OUT_W-1:0]     idx;
        logic                     last;
    } coef_word_t;

    // One directed stimulus row; exp_* only used when typed is set
    typedef struct packed {
        logic [FIELD_W-1:0]       ar;
        logic [FIELD_W-1:0]       ai;
        logic [FIELD_W-1:0]       br;
        logic [FIELD_W-1:0]       bi;
        logic                     fin;
        logic                     typed;
        logic signed [ACC_W-1:0]  exp_re;
        logic signed [ACC_W-1:0]  exp_im;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata;
    logic                     s_axis_tlast;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     m_axis_tlast;

    // Model state: both operands and their highest non-zero index
    longint                   a_re [MAX_TERMS];
    longint                   a_im [MAX_TERMS];
    longint                   b_re [MAX_TERMS];
    longint                   b_im [MAX_TERMS];
    int unsigned              load_idx;
    int unsigned              a_top;
    int unsigned              b_top;
    bit                       a_live;
    bit                       b_live;

    coef_word_t               coef_pending [$];
    stim_row_t                dir_table [$];
    int                       fault_count;
    int                       words_seen;
    int                       burst_left;
    int unsigned              cycle_count;

    complex_poly_multiply_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Advance the model by one accepted input word and queue the product words
    // it causes. A typed row replaces the computed single word by the hand value.
    task automatic absorb_word(input logic [IN_DATA_W-1:0] data, input logic fin,
                               input logic typed, input coef_word_t typed_word);
        logic signed [COEF_BITS-1:0] c;
        longint      ar, ai, br, bi, sr, si;
        int unsigned total, i, j, lo, hi;
        coef_word_t  w;
        // take the low COEF_BITS of each field, sign-extended
        c = data[0*FIELD_W +: COEF_BITS];
        ar = c;
        c = data[1*FIELD_W +: COEF_BITS];
        ai = c;
        c = data[2*FIELD_W +: COEF_BITS];
        br = c;
        c = data[3*FIELD_W +: COEF_BITS];
        bi = c;
        // drop coefficients beyond the store; tlast still acts on them
        if (load_idx < MAX_TERMS)
        begin
            a_re[load_idx] = ar;
            a_im[load_idx] = ai;
            b_re[load_idx] = br;
            b_im[load_idx] = bi;
            if (ar != 0 || ai != 0)
            begin
                a_top  = load_idx;
                a_live = 1'b1;
            end
            if (br != 0 || bi != 0)
            begin
                b_top  = load_idx;
                b_live = 1'b1;
            end
            load_idx++;
        end
        if (!fin)
            return;
        if (typed)
            coef_pending.insert(coef_pending.size(), typed_word);
        else if (!(a_live && b_live))
        begin
            // an all-zero operand gives a single zero word
            w.re   = '0;
            w.im   = '0;
            w.idx  = '0;
            w.last = 1'b1;
            coef_pending.insert(coef_pending.size(), w);
        end
        else
        begin
            total = a_top + b_top + 1;
            if (total > RESULT_CAP)
                total = RESULT_CAP;
            for (i = 0; i < total; i++)
            begin
                sr = 0;
                si = 0;
                lo = (i > b_top) ? i - b_top : 0;
                hi = (i < a_top) ? i : a_top;
                for (j = lo; j <= hi; j++)
                begin
                    sr += a_re[j] * b_re[i-j] - a_im[j] * b_im[i-j];
                    si += a_re[j] * b_im[i-j] + a_im[j] * b_re[i-j];
                end
                w.re   = sr[ACC_W-1:0];
                w.im   = si[ACC_W-1:0];
                w.idx  = i[IDX_OUT_W-1:0];
                w.last = (i + 1 == total);
                coef_pending.insert(coef_pending.size(), w);
            end
        end
        // start a fresh operand pair
        load_idx = 0;
        a_top    = 0;
        b_top    = 0;
        a_live   = 1'b0;
        b_live   = 1'b0;
    endtask

    // Offer one word on the input stream and hold it until the block takes it.
    // Bursts of random length with random gaps between them; a zero gap lets
    // bursts run together so that long unbroken stretches occur as well.
    task automatic offer_word(input logic [IN_DATA_W-1:0] data, input logic fin,
                              input logic typed, input coef_word_t typed_word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= data;
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_word(data, fin, typed, typed_word);
    endtask

    task automatic dir_row(input logic [FIELD_W-1:0] ar, input logic [FIELD_W-1:0] ai,
                           input logic [FIELD_W-1:0] br, input logic [FIELD_W-1:0] bi,
                           input logic fin, input logic typed,
                           input logic signed [ACC_W-1:0] exp_re,
                           input logic signed [ACC_W-1:0] exp_im);
        stim_row_t r;
        r.ar     = ar;
        r.ai     = ai;
        r.br     = br;
        r.bi     = bi;
        r.fin    = fin;
        r.typed  = typed;
        r.exp_re = exp_re;
        r.exp_im = exp_im;
        dir_table.insert(dir_table.size(), r);
    endtask

    // Coefficient value: extremes, zero and small values often, else anything
    function automatic logic [FIELD_W-1:0] pick_coef();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            3:       v = 16'hffff;
            4:       v = FIELD_W'($urandom_range(0, 63));
            default: v = FIELD_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Compare one accepted product word with the oldest expectation
    task automatic check_coef_word();
        coef_word_t exp_w;
        coef_word_t got_w;
        got_w.re   = m_axis_tdata[0 +: ACC_W];
        got_w.im   = m_axis_tdata[ACC_W +: ACC_W];
        got_w.idx  = m_axis_tdata[2*ACC_W +: IDX_OUT_W];
        got_w.last = m_axis_tlast;
        words_seen++;
        if (coef_pending.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("unexpected product word: re %0d im %0d idx %0d last %0b",
                         got_w.re, got_w.im, got_w.idx, got_w.last);
        end
        else
        begin
            exp_w = coef_pending.pop_front();
            if (got_w.re !== exp_w.re || got_w.im !== exp_w.im ||
                got_w.idx !== exp_w.idx || got_w.last !== exp_w.last)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("product mismatch: expected re %0d im %0d idx %0d last %0b, %s",
                             exp_w.re, exp_w.im, exp_w.idx, exp_w.last,
                             $sformatf("got re %0d im %0d idx %0d last %0b",
                                       got_w.re, got_w.im, got_w.idx, got_w.last));
            end
        end
    endtask

    // Receiver: take words at the output, stall on its own changing pattern,
    // and twice hold off for a long stretch so the block backs up its input.
    initial
    begin : drain
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_one_done;
        bit  hold_two_done;
        logic flip;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        hold_one_done = 1'b0;
        hold_two_done = 1'b0;
        flip          = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_coef_word();
            if (!hold_one_done && words_seen >= 40)
            begin
                hold_one_done = 1'b1;
                hold_left     = HOLD_TICKS;
            end
            if (!hold_two_done && words_seen >= 350)
            begin
                hold_two_done = 1'b1;
                hold_left     = HOLD_TICKS;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            flip = ~flip;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= flip;
                endcase
            end
        end
    end

    // Watchdog: count cycles and give up at a generous limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Sender: directed table first, then random operand pairs
    initial
    begin : feed
        coef_word_t          tw;
        stim_row_t           r;
        logic [FIELD_W-1:0]  ar, ai, br, bi;
        int                  sent, len, k, pick, a_cut, b_cut;
        bit                  zero_a, zero_b;

        fault_count = 0;
        words_seen  = 0;
        burst_left  = 0;
        load_idx    = 0;
        a_top       = 0;
        b_top       = 0;
        a_live      = 1'b0;
        b_live      = 1'b0;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;

        // single-word pairs: zero operands straight after reset, unit values, extremes
        dir_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 40'sd0, 40'sd0);
        dir_row(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 40'sd0, 40'sd0);
        dir_row(16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b1, 1'b1, 40'sd0, 40'sd0);
        dir_row(16'h4000, 16'h0000, 16'h4000, 16'h0000, 1'b1, 1'b1,
                40'sd268435456, 40'sd0);
        dir_row(16'h0000, 16'h4000, 16'h0000, 16'h4000, 1'b1, 1'b1,
                -40'sd268435456, 40'sd0);
        dir_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1,
                40'sd0, 40'sd2147483648);
        dir_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b1,
                -40'sd65535, -40'sd2147418112);
        dir_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1,
                40'sd0, 40'sd2147352578);
        // three-term pair, mixed signs
        dir_row(16'h03e8, 16'hf830, 16'h012c, 16'h0190, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'hec78, 16'h1b58, 16'hff9c, 16'h2328, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h007b, 16'hfe38, 16'h0315, 16'hfc0d, 1'b1, 1'b0, 40'sd0, 40'sd0);
        // trailing zeros: A tops out at 0, B at 1
        dir_row(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h0000, 16'h0000, 16'h2000, 16'h1000, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 40'sd0, 40'sd0);
        // A zero over two terms
        dir_row(16'h0000, 16'h0000, 16'h1234, 16'h0000, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h0000, 16'h0000, 16'h0000, 16'h5678, 1'b1, 1'b1, 40'sd0, 40'sd0);
        // extremes across three terms
        dir_row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 1'b0, 40'sd0, 40'sd0);
        dir_row(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b0, 40'sd0, 40'sd0);

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[n])
        begin
            r       = dir_table[n];
            tw.re   = r.exp_re;
            tw.im   = r.exp_im;
            tw.idx  = '0;
            tw.last = 1'b1;
            offer_word({r.bi, r.br, r.ai, r.ar}, r.fin, r.typed, tw);
        end

        // Random operand pairs: mostly short, some up to the full store, a few
        // running past it. Zero coefficients, zero operands and zero tails mixed in.
        tw   = '0;
        sent = 0;
        while (sent < WORD_GOAL)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                len = $urandom_range(1, 5);
            else if (pick < 17)
                len = $urandom_range(6, MAX_TERMS - 1);
            else if (pick < 19)
                len = MAX_TERMS;
            else
                len = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
            zero_a = ($urandom_range(0, 11) == 0);
            zero_b = ($urandom_range(0, 11) == 0);
            a_cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
            b_cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
            for (k = 0; k < len; k++)
            begin
                if (zero_a || k > a_cut || $urandom_range(0, 7) == 0)
                begin
                    ar = '0;
                    ai = '0;
                end
                else
                begin
                    ar = pick_coef();
                    ai = pick_coef();
                end
                if (zero_b || k > b_cut || $urandom_range(0, 7) == 0)
                begin
                    br = '0;
                    bi = '0;
                end
                else
                begin
                    br = pick_coef();
                    bi = pick_coef();
                end
                offer_word({bi, br, ai, ar}, (k == len - 1), 1'b0, tw);
                // words past the store are ignored by the block; do not count them
                if (k < MAX_TERMS)
                    sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain: wait for every expected word, then a little longer for strays
        while (coef_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (fault_count == 0 && coef_pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cpm_pkg.sv
hw/rtl/cpm_cell.sv
hw/rtl/complex_poly_multiply_core.sv
tb/tb.sv
